@@ hw/rtl/pps_pkg.sv @@
package pps_pkg;

    // Fixed field widths of the process records and results.
    localparam int TIME_W = 16;
    localparam int PRIO_W = 8;
    localparam int CLK_W  = 21;
    localparam int ID_W   = 5;
    localparam int WAIT_W = 20;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } t_state;

    // One stored process record.
    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } t_record;

    // Running results of one scan over the stored processes.
    typedef struct packed {
        logic              best_v;
        logic [PRIO_W-1:0] best_prio;
        logic [TIME_W-1:0] best_arr;
        logic [TIME_W-1:0] best_rem;
        logic              fut_v;
        logic [TIME_W-1:0] fut;
    } t_scan_acc;

endpackage

@@ hw/rtl/pps_if.sv @@
// Channel carrying one process record per transaction.
interface pps_in_if;
    logic                       valid;
    logic                       ready;
    logic [pps_pkg::TIME_W-1:0] arrival_time;
    logic [pps_pkg::TIME_W-1:0] burst_length;
    logic [pps_pkg::PRIO_W-1:0] prio_level;
    logic                       last_record;

    modport source (output valid, arrival_time, burst_length, prio_level, last_record,
                    input ready);
    modport sink (input valid, arrival_time, burst_length, prio_level, last_record,
                  output ready);
endinterface

// Channel carrying one per-process result per transaction.
interface pps_out_if;
    logic                       valid;
    logic                       ready;
    logic [pps_pkg::ID_W-1:0]   proc_id;
    logic [pps_pkg::CLK_W-1:0]  finish_time;
    logic [pps_pkg::CLK_W-1:0]  turnaround;
    logic [pps_pkg::WAIT_W-1:0] wait_time;
    logic                       final_result;

    modport source (output valid, proc_id, finish_time, turnaround, wait_time, final_result,
                    input ready);
    modport sink (input valid, proc_id, finish_time, turnaround, wait_time, final_result,
                  output ready);
endinterface

@@ hw/rtl/preemptive_priority_scheduler_top.sv @@
// Channel  Direction  Payload
// i_in     sink       arrival_time, burst_length, prio_level, last_record
// o_out    source     proc_id, finish_time, turnaround, wait_time, final_result
//
// A record is taken whenever i_in.valid is high in the idle state; the record with last_record starts the schedule.
// Each scheduling round scans the n stored processes through one compare unit and a
// registered memory read port, and a batch needs at most 2n + 1 rounds.
// Each result then passes through ST_OUT_RD, ST_OUT_LOAD and ST_OUT_WAIT and is held until o_out.ready is high.
// Reset is synchronous and clears the sequencer and counts; the stores are not reset.
// No record is taken from the last record until the last result has gone out.
module preemptive_priority_scheduler_top #(
    parameter int MAX_PROCS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pps_in_if.sink      i_in,
    pps_out_if.source   o_out
);
    import pps_pkg::*;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_done;
    logic [CNT_W-1:0]    r_idx;
    logic [CLK_W-1:0]    r_clk;
    t_scan_acc           r_acc;
    logic [IDX_W-1:0]    r_best_idx;
    logic [TIME_W-1:0]   r_span;

    // Memories and their read data.
    t_record             rec_mem [MAX_PROCS];
    logic [TIME_W-1:0]   rem_mem [MAX_PROCS];
    logic [CLK_W-1:0]    fin_mem [MAX_PROCS];
    t_record             r_rec_rd;
    logic [TIME_W-1:0]   r_rem_rd;
    logic [CLK_W-1:0]    r_fin_rd;

    // Output register.
    logic                r_out_valid;
    logic [ID_W-1:0]     r_proc_id;
    logic [CLK_W-1:0]    r_finish;
    logic [CLK_W-1:0]    r_tat;
    logic [WAIT_W-1:0]   r_wait;
    logic                r_final;

    logic                in_ready;
    logic                in_accept;
    logic                rec_we;
    logic                rem_we;
    logic                fin_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [IDX_W-1:0]    rd_addr;
    logic [TIME_W-1:0]   rem_wd;
    t_record             load_rec;
    logic                store_free;
    logic [CNT_W-1:0]    eval_idx;
    logic                sel_take;
    t_scan_acc           sel_acc;
    logic [TIME_W-1:0]   gap;
    logic [CLK_W-1:0]    clk_sum;
    logic [TIME_W-1:0]   rem_left;
    logic                rem_zero;
    logic [CNT_W:0]      idx_plus;
    logic [CNT_W:0]      done_plus;
    logic                last_out;
    logic [CLK_W-1:0]    tat_calc;
    logic [CLK_W-1:0]    wait_calc;

    // Shared compare unit of the scan.
    pps_select u_select (
        .i_acc      (r_acc),
        .i_rec      (r_rec_rd),
        .i_rem      (r_rem_rd),
        .i_sim_time (r_clk),
        .o_take     (sel_take),
        .o_acc      (sel_acc)
    );

    // Datapath helpers.
    always_comb begin
        load_rec.arrival = i_in.arrival_time;
        load_rec.burst   = (i_in.burst_length == '0) ? TIME_W'(1) : i_in.burst_length;
        load_rec.prio    = i_in.prio_level;
        store_free = (r_count < CNT_W'(MAX_PROCS));
        in_accept  = i_in.valid && in_ready;
        eval_idx   = r_idx - CNT_W'(1);
        rd_addr    = r_idx[IDX_W-1:0];
        gap        = r_acc.fut - r_clk[TIME_W-1:0];
        clk_sum    = r_clk + CLK_W'(r_span);
        rem_left   = r_acc.best_rem - r_span;
        rem_zero   = (rem_left == '0);
        idx_plus   = {1'b0, r_idx} + (CNT_W+1)'(1);
        done_plus  = {1'b0, r_done} + (CNT_W+1)'(1);
        last_out   = (idx_plus == {1'b0, r_count});
        tat_calc   = r_fin_rd - CLK_W'(r_rec_rd.arrival);
        wait_calc  = tat_calc - CLK_W'(r_rec_rd.burst);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && i_in.last_record) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_count) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = r_acc.best_v ? ST_UPDATE : ST_SCAN;
            end
            ST_UPDATE: begin
                n_state = (rem_zero && (done_plus == {1'b0, r_count})) ? ST_OUT_RD : ST_SCAN;
            end
            ST_OUT_RD: begin
                n_state = ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                n_state = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (o_out.ready) begin
                    n_state = last_out ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake and memory write controls.
    always_comb begin
        in_ready = 1'b0;
        rec_we   = 1'b0;
        rem_we   = 1'b0;
        fin_we   = 1'b0;
        wr_addr  = r_best_idx;
        rem_wd   = rem_left;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                wr_addr  = r_count[IDX_W-1:0];
                rem_wd   = load_rec.burst;
                rec_we   = in_accept && store_free;
                rem_we   = in_accept && store_free;
            end
            ST_UPDATE: begin
                rem_we = 1'b1;
                fin_we = rem_zero;
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.proc_id      = r_proc_id;
    assign o_out.finish_time  = r_finish;
    assign o_out.turnaround   = r_tat;
    assign o_out.wait_time    = r_wait;
    assign o_out.final_result = r_final;

    // Record, remaining-work and finish-time memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            rec_mem[wr_addr] <= load_rec;
        end
        if (rem_we) begin
            rem_mem[wr_addr] <= rem_wd;
        end
        if (fin_we) begin
            fin_mem[wr_addr] <= clk_sum;
        end
        r_rec_rd <= rec_mem[rd_addr];
        r_rem_rd <= rem_mem[rd_addr];
        r_fin_rd <= fin_mem[rd_addr];
    end

    // Sequencer registers and counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_done      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        if (store_free) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_idx  <= '0;
                        r_done <= '0;
                    end
                end
                ST_SCAN: begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                ST_DECIDE: begin
                    r_idx <= '0;
                end
                ST_UPDATE: begin
                    if (rem_zero) begin
                        r_done <= r_done + CNT_W'(1);
                    end
                    r_idx <= '0;
                end
                ST_OUT_RD: begin
                end
                ST_OUT_LOAD: begin
                    r_out_valid <= 1'b1;
                end
                ST_OUT_WAIT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (last_out) begin
                            r_count <= '0;
                            r_done  <= '0;
                            r_idx   <= '0;
                        end else begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Scheduling datapath and result payload.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_clk <= '0;
            end
            ST_SCAN: begin
                if (r_idx == '0) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= sel_acc;
                    if (sel_take) begin
                        r_best_idx <= eval_idx[IDX_W-1:0];
                    end
                end
            end
            ST_DECIDE: begin
                if (!r_acc.best_v) begin
                    r_clk <= CLK_W'(r_acc.fut);
                end else if (r_acc.fut_v && (gap < r_acc.best_rem)) begin
                    r_span <= gap;
                end else begin
                    r_span <= r_acc.best_rem;
                end
            end
            ST_UPDATE: begin
                r_clk <= clk_sum;
            end
            ST_OUT_LOAD: begin
                r_proc_id <= ID_W'(idx_plus);
                r_finish  <= r_fin_rd;
                r_tat     <= tat_calc;
                r_wait    <= wait_calc[WAIT_W-1:0];
                r_final   <= last_out;
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // The store count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PROCS))
        else $error("process count exceeds capacity");

    // Results go out only once every stored process has finished.
    a_all_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_done == r_count))
        else $error("result shown before schedule completed");

    // A run step advances by at least one unit and never past the remaining work.
    a_span_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> ((r_span != '0) && (r_span <= r_acc.best_rem)))
        else $error("bad run span");

    // After the final result is taken, the block takes records again.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.final_result) |=> i_in.ready)
        else $error("input not reopened after final result");
`endif

endmodule

@@ hw/rtl/pps_select.sv @@
// Compare unit shared by every step of a scan: folds one stored process into the
// running choice of the process to run and the earliest future arrival.
module pps_select (
    input  pps_pkg::t_scan_acc               i_acc,
    input  pps_pkg::t_record                 i_rec,
    input  logic [pps_pkg::TIME_W-1:0]       i_rem,
    input  logic [pps_pkg::CLK_W-1:0]        i_sim_time,
    output logic                             o_take,
    output pps_pkg::t_scan_acc               o_acc
);
    import pps_pkg::*;

    logic pending;
    logic arrived;
    logic future;

    // Classify the process against the current simulated time.
    always_comb begin
        pending = (i_rem != '0);
        arrived = (CLK_W'(i_rec.arrival) <= i_sim_time);
        o_take  = pending && arrived &&
                  (!i_acc.best_v || (i_rec.prio < i_acc.best_prio) ||
                   ((i_rec.prio == i_acc.best_prio) && (i_rec.arrival < i_acc.best_arr)));
        future  = pending && !arrived && (!i_acc.fut_v || (i_rec.arrival < i_acc.fut));
    end

    // Update the running choice.
    always_comb begin
        o_acc = i_acc;
        if (o_take) begin
            o_acc.best_v    = 1'b1;
            o_acc.best_prio = i_rec.prio;
            o_acc.best_arr  = i_rec.arrival;
            o_acc.best_rem  = i_rem;
        end
        if (future) begin
            o_acc.fut_v = 1'b1;
            o_acc.fut   = i_rec.arrival;
        end
    end

endmodule

@@ sim/pps_sched_checker.sv @@
`timescale 1ns / 100ps

// Scoreboard for the preemptive priority scheduler. It keeps its own copy of the
// loaded process records, works out the whole schedule of a batch when the closing
// record is accepted, and compares every result transaction with the oldest
// expectation.
module pps_sched_checker #(
    parameter int MAX_PROCS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pps_in_if    i_in,
    pps_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import pps_pkg::*;

    // One per-process result as the block should report it.
    typedef struct packed {
        logic [ID_W-1:0]   proc_id;
        logic [CLK_W-1:0]  finish_time;
        logic [CLK_W-1:0]  turnaround;
        logic [WAIT_W-1:0] wait_time;
        logic              final_result;
    } t_proc_result;

    t_record      held_records [MAX_PROCS];
    int           held_count;
    t_proc_result pending_results[$];

    initial begin
        held_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // True when process a is to run ahead of process b.
    function automatic bit outranks(int a, int b);
        if (held_records[a].prio != held_records[b].prio) begin
            return held_records[a].prio < held_records[b].prio;
        end
        if (held_records[a].arrival != held_records[b].arrival) begin
            return held_records[a].arrival < held_records[b].arrival;
        end
        return a < b;
    endfunction

    // Runs the held batch to completion and queues one result per process.
    // Time advances in spans: a process runs until it is done or the next
    // arrival could preempt it, and an empty ready set jumps to the next arrival.
    function automatic void schedule_batch();
        logic [TIME_W-1:0] work_left [MAX_PROCS];
        logic [CLK_W-1:0]  done_at [MAX_PROCS];
        logic [CLK_W-1:0]  now;
        logic [CLK_W-1:0]  span;
        logic [CLK_W-1:0]  next_arrival;
        int                best;
        int                finished;
        t_proc_result      res;

        for (int i = 0; i < held_count; i++) begin
            work_left[i] = held_records[i].burst;
        end
        now      = '0;
        finished = 0;
        while (finished < held_count) begin
            best = -1;
            for (int i = 0; i < held_count; i++) begin
                if (work_left[i] != 0 && held_records[i].arrival <= now) begin
                    if (best < 0 || outranks(i, best)) begin
                        best = i;
                    end
                end
            end
            if (best < 0) begin
                next_arrival = '1;
                for (int i = 0; i < held_count; i++) begin
                    if (work_left[i] != 0 && held_records[i].arrival < next_arrival) begin
                        next_arrival = CLK_W'(held_records[i].arrival);
                    end
                end
                now = next_arrival;
            end else begin
                span = CLK_W'(work_left[best]);
                for (int i = 0; i < held_count; i++) begin
                    if (work_left[i] != 0 && held_records[i].arrival > now &&
                        held_records[i].arrival - now < span) begin
                        span = held_records[i].arrival - now;
                    end
                end
                now = now + span;
                work_left[best] = TIME_W'(CLK_W'(work_left[best]) - span);
                if (work_left[best] == 0) begin
                    done_at[best] = now;
                    finished++;
                end
            end
        end

        for (int i = 0; i < held_count; i++) begin
            res.proc_id      = ID_W'(i + 1);
            res.finish_time  = done_at[i];
            res.turnaround   = done_at[i] - CLK_W'(held_records[i].arrival);
            res.wait_time    = WAIT_W'(res.turnaround - CLK_W'(held_records[i].burst));
            res.final_result = (i == held_count - 1);
            pending_results  = {pending_results, res};
        end
        held_count = 0;
    endfunction

    function automatic void check_field(string label, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            o_fail_count++;
        end
    endfunction

    // Both channels are sampled at the rising edge. Results are checked before the
    // record of the same edge is taken, since a result never follows its record in
    // the same cycle.
    always @(posedge i_clk) begin
        t_proc_result want;
        t_record      rec;

        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual id %0d finish %0d",
                             $time, i_out.proc_id, i_out.finish_time);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("proc_id", want.proc_id, i_out.proc_id);
                    check_field("finish_time", want.finish_time, i_out.finish_time);
                    check_field("turnaround", want.turnaround, i_out.turnaround);
                    check_field("wait_time", want.wait_time, i_out.wait_time);
                    check_field("final_result", want.final_result, i_out.final_result);
                end
            end

            // A zero burst counts as one unit; records past a full store are dropped.
            if (i_in.valid && i_in.ready) begin
                rec.arrival = i_in.arrival_time;
                rec.burst   = (i_in.burst_length == 0) ? TIME_W'(1) : i_in.burst_length;
                rec.prio    = i_in.prio_level;
                if (held_count < MAX_PROCS) begin
                    held_records[held_count] = rec;
                    held_count++;
                end
                if (i_in.last_record) begin
                    schedule_batch();
                end
            end
            o_pending = pending_results.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import pps_pkg::*;

    localparam int          MAX_PROCS      = 16;
    localparam int          DIRECTED_COUNT = 25;
    localparam int          RANDOM_RECORDS = 195;
    localparam int          PHASE_LEN      = (DIRECTED_COUNT + RANDOM_RECORDS) / 3;
    localparam int          DRAIN_CYCLES   = 64;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct = 27;
    int   recv_idle_pct = 71;
    int   records_sent  = 0;
    int   fail_count;
    int   pending;

    pps_in_if  in_ch ();
    pps_out_if out_ch ();

    preemptive_priority_scheduler_top #(
        .MAX_PROCS(MAX_PROCS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    pps_sched_checker #(
        .MAX_PROCS(MAX_PROCS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends a hung run.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Result backpressure, redrawn every cycle.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sends one record. Called at a falling edge and returns at the falling edge
    // after the transaction. The idle mix follows the number of records sent so far.
    task automatic send_record(input logic [TIME_W-1:0] arrival,
                               input logic [TIME_W-1:0] burst,
                               input logic [PRIO_W-1:0] prio,
                               input logic              last);
        if (records_sent < PHASE_LEN) begin
            send_idle_pct = 27;
            recv_idle_pct = 71;
        end else if (records_sent < 2 * PHASE_LEN) begin
            send_idle_pct = 71;
            recv_idle_pct = 27;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.arrival_time <= arrival;
        in_ch.burst_length <= burst;
        in_ch.prio_level   <= prio;
        in_ch.last_record  <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        records_sent++;
        @(negedge i_clk);
    endtask

    // One batch of random records closed by a last record. Most batches are small; one
    // style keeps them crowded so that preemption and ties are frequent, another spreads over
    // the full field ranges, a third mixes the two, and a few fill or overflow the store.
    task automatic send_random_batch();
        int                size;
        int                style;
        int                roll;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRIO_W-1:0] prio;

        roll = $urandom_range(99);
        if (roll < 8) begin
            size = $urandom_range(MAX_PROCS + 4, MAX_PROCS);
        end else if (roll < 25) begin
            size = 1;
        end else begin
            size = $urandom_range(8, 2);
        end
        style = $urandom_range(2);
        for (int k = 0; k < size; k++) begin
            arrival = TIME_W'($urandom_range(24));
            burst   = TIME_W'($urandom_range(12));
            prio    = PRIO_W'($urandom_range(3));
            if (style == 1 || (style == 2 && $urandom_range(1) == 1)) begin
                arrival = TIME_W'($urandom);
            end
            if (style == 1 || (style == 2 && $urandom_range(1) == 1)) begin
                burst = TIME_W'($urandom);
            end
            if (style == 1 || (style == 2 && $urandom_range(1) == 1)) begin
                prio = PRIO_W'($urandom);
            end
            send_record(arrival, burst, prio, k == size - 1);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.arrival_time = '0;
        in_ch.burst_length = '0;
        in_ch.prio_level   = '0;
        in_ch.last_record  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Two zero bursts with equal priority and arrival: the lower id runs first.
        send_record('0, '0, '0, 1'b0);
        send_record('0, '0, '0, 1'b1);

        // Preemption, a priority tie broken by arrival time, then an idle gap.
        send_record(16'd0, 16'd10, 8'd5, 1'b0);
        send_record(16'd2, 16'd3, 8'd1, 1'b0);
        send_record(16'd3, 16'd2, 8'd1, 1'b0);
        send_record(16'd100, 16'd4, 8'd0, 1'b1);

        // Single process at the top of every field.
        send_record('1, '1, '1, 1'b1);

        // Full store of maximal records reaching the largest finish time, then two
        // records that are dropped, the second one closing the batch.
        for (int k = 0; k < MAX_PROCS + 2; k++) begin
            send_record('1, (k == MAX_PROCS + 1) ? '0 : '1,
                        (k % 2 == 1) ? 8'd255 : 8'd0, k == MAX_PROCS + 1);
        end

        while (records_sent < DIRECTED_COUNT + RANDOM_RECORDS) begin
            send_random_batch();
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
